// ----- design/splc_pkg.sv -----
// shared constants and types of the sampling profiler load counter
package splc_pkg;

    localparam int NUM_REGIONS = 16;
    localparam int COUNT_W     = 32;
    localparam int DIGIT_W     = 4;
    localparam int NUM_DIGITS  = COUNT_W / DIGIT_W;
    localparam int DIGIT_CNT_W = $clog2(NUM_DIGITS);
    localparam int KIND_W      = 2;
    localparam int REGION_W    = 4;
    localparam int IDX_W       = $clog2(NUM_REGIONS);
    localparam int LOAD_SHIFT  = 10;
    localparam int LOAD_W      = LOAD_SHIFT + 1;
    localparam int LOAD_MAX    = 1 << LOAD_SHIFT;
    localparam int DIV_CNT_W   = $clog2(LOAD_W);

    typedef logic [COUNT_W-1:0] count_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK  = 2'd0,
        KIND_QUERY = 2'd1,
        KIND_CLEAR = 2'd2
    } kind_t;

    typedef struct packed {
        logic done;
        logic full;
    } inc_status_t;

endpackage

// ----- design/splc_inc.sv -----
// digit-serial incrementer for a region counter and the total counter
module splc_inc (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  splc_pkg::count_t      region_in,
    input  splc_pkg::count_t      total_in,
    output splc_pkg::count_t      region_out,
    output splc_pkg::count_t      total_out,
    output splc_pkg::inc_status_t status
);
    import splc_pkg::*;

    count_t                 reg_sr_reg;
    count_t                 reg_sr_next;
    count_t                 tot_sr_reg;
    count_t                 tot_sr_next;
    logic                   rcarry_reg;
    logic                   rcarry_next;
    logic                   tcarry_reg;
    logic                   tcarry_next;
    logic                   full_reg;
    logic                   full_next;
    logic                   run_reg;
    logic                   run_next;
    logic                   done_reg;
    logic                   done_next;
    logic [DIGIT_CNT_W-1:0] cnt_reg;
    logic [DIGIT_CNT_W-1:0] cnt_next;
    logic [DIGIT_W:0]       rsum;
    logic [DIGIT_W:0]       tsum;

    always_comb
    begin
        rsum        = {1'b0, reg_sr_reg[DIGIT_W-1:0]} + (DIGIT_W+1)'(rcarry_reg);
        tsum        = {1'b0, tot_sr_reg[DIGIT_W-1:0]} + (DIGIT_W+1)'(tcarry_reg);
        reg_sr_next = reg_sr_reg;
        tot_sr_next = tot_sr_reg;
        rcarry_next = rcarry_reg;
        tcarry_next = tcarry_reg;
        full_next   = full_reg;
        run_next    = run_reg;
        cnt_next    = cnt_reg;
        done_next   = 1'b0;
        if (load)
        begin
            reg_sr_next = region_in;
            tot_sr_next = total_in;
            rcarry_next = 1'b1;
            tcarry_next = 1'b1;
            full_next   = 1'b1;
            run_next    = 1'b1;
            cnt_next    = '0;
        end
        else if (run_reg)
        begin
            // lowest digit leaves at the bottom, its sum enters at the top
            reg_sr_next = {rsum[DIGIT_W-1:0], reg_sr_reg[COUNT_W-1:DIGIT_W]};
            tot_sr_next = {tsum[DIGIT_W-1:0], tot_sr_reg[COUNT_W-1:DIGIT_W]};
            rcarry_next = rsum[DIGIT_W];
            tcarry_next = tsum[DIGIT_W];
            full_next   = full_reg & (&tsum[DIGIT_W-1:0]);
            cnt_next    = cnt_reg + 1'b1;
            if (cnt_reg == DIGIT_CNT_W'(NUM_DIGITS - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rcarry_reg <= 1'b0;
            tcarry_reg <= 1'b0;
            full_reg   <= 1'b0;
            run_reg    <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            rcarry_reg <= rcarry_next;
            tcarry_reg <= tcarry_next;
            full_reg   <= full_next;
            run_reg    <= run_next;
            done_reg   <= done_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        reg_sr_reg <= reg_sr_next;
        tot_sr_reg <= tot_sr_next;
    end

    assign region_out  = reg_sr_reg;
    assign total_out   = tot_sr_reg;
    assign status.done = done_reg;
    assign status.full = full_reg;

endmodule

// ----- design/splc_div.sv -----
// radix-2 restoring divider for the scaled load share
module splc_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  splc_pkg::count_t              samples,
    input  splc_pkg::count_t              total,
    output logic                          done,
    output logic [splc_pkg::LOAD_W-1:0]   quotient
);
    import splc_pkg::*;

    count_t               rem_reg;
    count_t               rem_next;
    count_t               div_reg;
    count_t               div_next;
    logic [LOAD_W-1:0]    dvd_reg;
    logic [LOAD_W-1:0]    dvd_next;
    logic [LOAD_W-1:0]    q_reg;
    logic [LOAD_W-1:0]    q_next;
    logic                 sat_reg;
    logic                 sat_next;
    logic                 run_reg;
    logic                 run_next;
    logic                 done_reg;
    logic                 done_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;
    logic [COUNT_W:0]     trial;
    logic [COUNT_W+1:0]   diff;
    logic                 ge;

    always_comb
    begin
        trial     = {rem_reg, dvd_reg[LOAD_W-1]};
        diff      = {1'b0, trial} - {2'b0, div_reg};
        ge        = !diff[COUNT_W+1];
        rem_next  = rem_reg;
        div_next  = div_reg;
        dvd_next  = dvd_reg;
        q_next    = q_reg;
        sat_next  = sat_reg;
        run_next  = run_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (load)
        begin
            // dividend is samples << LOAD_SHIFT, consumed from the top
            rem_next = {1'b0, samples[COUNT_W-1:1]};
            dvd_next = {samples[0], {LOAD_SHIFT{1'b0}}};
            div_next = total;
            sat_next = samples > total;
            q_next   = '0;
            run_next = 1'b1;
            cnt_next = '0;
        end
        else if (run_reg)
        begin
            rem_next = ge ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
            q_next   = {q_reg[LOAD_W-2:0], ge};
            dvd_next = {dvd_reg[LOAD_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(LOAD_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        div_reg <= div_next;
        dvd_reg <= dvd_next;
        q_reg   <= q_next;
        sat_reg <= sat_next;
    end

    assign done     = done_reg;
    assign quotient = sat_reg ? LOAD_W'(LOAD_MAX) : q_reg;

endmodule

// ----- design/sampling_profile_load_counter_core.sv -----
// top level of the sampling profiler load counter: counter bank and sequencing
// A command is taken when start is high and busy is low. A sample tick holds
// busy while the region counter and the total go through a 4-bit
// digit-serial incrementer (8 digit steps), then are written back, halved
// together with all other region counters when the total reaches 2^32-1.
// A load query with a nonzero total runs an 11-step radix-2 divider and raises
// done with load_share when it finishes; a query of an empty total
// or an unknown region answers in the next cycle. A clear does not raise busy and
// gives no result. done lasts one cycle and cannot be held off, so load_share
// must be captured while done is high.
module sampling_profile_load_counter_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [splc_pkg::KIND_W-1:0]   kind,
    input  logic [splc_pkg::REGION_W-1:0] active_region,
    input  logic [splc_pkg::REGION_W-1:0] query_region,
    output logic                          done,
    output logic [splc_pkg::LOAD_W-1:0]   load_share
);
    import splc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INC,
        ST_DIV
    } state_t;

    state_t            state_reg;
    logic              done_reg;
    logic [LOAD_W-1:0] load_share_reg;
    count_t            bank_reg [NUM_REGIONS];
    count_t            bank_next [NUM_REGIONS];
    count_t            total_reg;
    count_t            total_next;
    logic [IDX_W-1:0]  sel_reg;
    logic [IDX_W-1:0]  rd_idx;
    count_t            rd_val;
    logic              accept;
    logic              tick_ok;
    logic              query_ok;
    logic              inc_load;
    logic              div_load;
    count_t            inc_region;
    count_t            inc_total;
    inc_status_t       inc_stat;
    logic              div_done;
    logic [LOAD_W-1:0] div_q;
    count_t            wb_val;

    assign busy     = (state_reg != ST_IDLE);
    assign accept   = start && !busy;
    assign tick_ok  = (kind == KIND_TICK) && (int'(active_region) < NUM_REGIONS);
    assign query_ok = (kind == KIND_QUERY) && (int'(query_region) < NUM_REGIONS);
    assign rd_idx   = (kind == KIND_TICK) ? IDX_W'(active_region) : IDX_W'(query_region);
    assign rd_val   = bank_reg[rd_idx];
    assign inc_load = accept && tick_ok;
    assign div_load = accept && query_ok && (total_reg != '0);

    splc_inc u_inc (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (inc_load),
        .region_in  (rd_val),
        .total_in   (total_reg),
        .region_out (inc_region),
        .total_out  (inc_total),
        .status     (inc_stat)
    );

    splc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (div_load),
        .samples  (rd_val),
        .total    (total_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            done_reg       <= 1'b0;
            load_share_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (inc_load)
                    begin
                        state_reg <= ST_INC;
                    end
                    else if (div_load)
                    begin
                        state_reg <= ST_DIV;
                    end
                    else if (accept && (kind == KIND_QUERY))
                    begin
                        done_reg       <= 1'b1;
                        load_share_reg <= '0;
                    end
                end
                ST_INC:
                begin
                    if (inc_stat.done)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        done_reg       <= 1'b1;
                        load_share_reg <= div_q;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // write-back of an increment, halving everything when the total saturates; a clear zeroes everything
    always_comb
    begin
        wb_val     = '0;
        total_next = total_reg;
        for (int i = 0; i < NUM_REGIONS; i++)
        begin
            bank_next[i] = bank_reg[i];
        end
        if (accept && (kind == KIND_CLEAR))
        begin
            total_next = '0;
            for (int i = 0; i < NUM_REGIONS; i++)
            begin
                bank_next[i] = '0;
            end
        end
        else if (inc_stat.done)
        begin
            total_next = inc_stat.full ? (inc_total >> 1) : inc_total;
            for (int i = 0; i < NUM_REGIONS; i++)
            begin
                wb_val       = (IDX_W'(i) == sel_reg) ? inc_region : bank_reg[i];
                bank_next[i] = inc_stat.full ? (wb_val >> 1) : wb_val;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
            for (int i = 0; i < NUM_REGIONS; i++)
            begin
                bank_reg[i] <= '0;
            end
        end
        else
        begin
            total_reg <= total_next;
            for (int i = 0; i < NUM_REGIONS; i++)
            begin
                bank_reg[i] <= bank_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (inc_load)
        begin
            sel_reg <= rd_idx;
        end
    end

    assign done       = done_reg;
    assign load_share = load_share_reg;

    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(state_reg) == ST_DIV) ||
                 $past(start && !busy && (kind == KIND_QUERY)))
        else $error("result strobe without a query");

    a_load_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (load_share <= LOAD_W'(LOAD_MAX)))
        else $error("load above full scale");

    a_inc_state: assert property (@(posedge clk) disable iff (!rst_n)
        inc_stat.done |-> (state_reg == ST_INC))
        else $error("increment finished outside its state");

    a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("division finished outside its state");

    a_div_total: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (total_reg != '0) && $stable(total_reg))
        else $error("division by an empty or changing total");

endmodule

// ----- sim/tb.sv -----
// testbench for the sampling profiler load counter: directed table, random ticks and queries
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import splc_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int                RANDOM_ITEMS = 450;
    localparam int                CYCLE_LIMIT  = 200000;
    localparam int                DRAIN_CYCLES = 24;
    localparam int                REPORT_MAX   = 10;

    typedef struct {
        logic [KIND_W-1:0]   op;
        logic [REGION_W-1:0] tick_region;
        logic [REGION_W-1:0] ask_region;
        bit                  typed;
        logic [LOAD_W-1:0]   typed_load;
    } stim_row_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [KIND_W-1:0]   kind;
    logic [REGION_W-1:0] active_region;
    logic [REGION_W-1:0] query_region;
    logic                done;
    logic [LOAD_W-1:0]   load_share;

    count_t            region_count [NUM_REGIONS];
    count_t            sample_total;
    logic [LOAD_W-1:0] load_expected [$];
    stim_row_t         directed_rows [$];

    int mismatches;
    int loads_checked;
    int n_ticks;
    int n_queries;
    int n_clears;
    int n_ignored;
    int cycle_count;

    sampling_profile_load_counter_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .kind          (kind),
        .active_region (active_region),
        .query_region  (query_region),
        .done          (done),
        .load_share    (load_share)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic void clear_profile();
        for (int r = 0; r < NUM_REGIONS; r++)
            region_count[r] = '0;
        sample_total = '0;
    endfunction

    function automatic logic [LOAD_W-1:0] region_load(input logic [REGION_W-1:0] r);
        logic [63:0] quotient;
        if (r >= NUM_REGIONS || sample_total == '0)
            return '0;
        quotient = ({32'd0, region_count[r]} << LOAD_SHIFT) / {32'd0, sample_total};
        if (quotient > LOAD_MAX)
            quotient = 64'(LOAD_MAX);
        return quotient[LOAD_W-1:0];
    endfunction

    // advances the profile state; returns 1 when the item yields a load result
    function automatic bit profile_apply(input logic [KIND_W-1:0] op,
                                         input logic [REGION_W-1:0] tick_r,
                                         input logic [REGION_W-1:0] ask_r,
                                         output logic [LOAD_W-1:0] load);
        load = '0;
        case (op)
            KIND_TICK:
            begin
                n_ticks++;
                if (tick_r < NUM_REGIONS)
                begin
                    region_count[tick_r] = region_count[tick_r] + 1;
                    sample_total = sample_total + 1;
                    if (sample_total == '1)
                    begin
                        for (int r = 0; r < NUM_REGIONS; r++)
                            region_count[r] = region_count[r] >> 1;
                        sample_total = sample_total >> 1;
                    end
                end
                return 1'b0;
            end
            KIND_QUERY:
            begin
                n_queries++;
                load = region_load(ask_r);
                return 1'b1;
            end
            KIND_CLEAR:
            begin
                n_clears++;
                clear_profile();
                return 1'b0;
            end
            default:
            begin
                n_ignored++;
                return 1'b0;
            end
        endcase
    endfunction

    task automatic send_item(input logic [KIND_W-1:0] op,
                             input logic [REGION_W-1:0] tick_r,
                             input logic [REGION_W-1:0] ask_r,
                             input bit typed,
                             input logic [LOAD_W-1:0] typed_load,
                             input bit may_idle);
        logic [LOAD_W-1:0] predicted;
        bit                has_load;
        bit                taken;
        start         <= !(may_idle && $urandom_range(99) < 29);
        kind          <= op;
        active_region <= tick_r;
        query_region  <= ask_r;
        do
        begin
            @(posedge clk);
            taken = start && !busy;
            if (!taken)
                start <= !(may_idle && $urandom_range(99) < 29);
        end
        while (!taken);
        has_load = profile_apply(op, tick_r, ask_r, predicted);
        if (has_load)
            load_expected.push_back(typed ? typed_load : predicted);
    endtask

    task automatic add_row(input logic [KIND_W-1:0] op, input int tick_r, input int ask_r,
                           input bit typed = 1'b0, input int typed_load = 0);
        stim_row_t row;
        row.op          = op;
        row.tick_region = REGION_W'(tick_r);
        row.ask_region  = REGION_W'(ask_r);
        row.typed       = typed;
        row.typed_load  = LOAD_W'(typed_load);
        directed_rows.push_back(row);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (load_expected.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("load_share %0d with no query pending", load_share);
            end
            else
            begin
                loads_checked++;
                if (load_share !== load_expected[0])
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("load_share mismatch: expected %0d, got %0d",
                                 load_expected[0], load_share);
                end
                void'(load_expected.pop_front());
            end
        end
    end

    initial
    begin
        logic [KIND_W-1:0]   op;
        logic [REGION_W-1:0] tick_r;
        logic [REGION_W-1:0] ask_r;
        int                  roll;
        int                  drain;

        start         <= 1'b0;
        kind          <= KIND_TICK;
        active_region <= '0;
        query_region  <= '0;
        rst_n         <= 1'b0;
        mismatches    = 0;
        loads_checked = 0;
        n_ticks       = 0;
        n_queries     = 0;
        n_clears      = 0;
        n_ignored     = 0;
        cycle_count   = 0;
        clear_profile();

        add_row(KIND_QUERY, 0, 0, 1'b1, 0);
        add_row(KIND_QUERY, 15, 15, 1'b1, 0);
        add_row(KIND_TICK, 0, 9);
        add_row(KIND_QUERY, 6, 0, 1'b1, 1024);
        add_row(KIND_QUERY, 0, 15, 1'b1, 0);
        add_row(KIND_TICK, 15, 0);
        add_row(KIND_QUERY, 3, 15, 1'b1, 512);
        add_row(KIND_TICK, 15, 15);
        add_row(KIND_QUERY, 0, 15);
        add_row(KIND_UNUSED, 15, 15);
        add_row(KIND_QUERY, 15, 0);
        add_row(KIND_TICK, 7, 0);
        add_row(KIND_TICK, 8, 0);
        add_row(KIND_QUERY, 0, 7);
        add_row(KIND_QUERY, 0, 8);
        add_row(KIND_QUERY, 0, 3, 1'b1, 0);
        add_row(KIND_CLEAR, 15, 15);
        add_row(KIND_QUERY, 0, 0, 1'b1, 0);
        add_row(KIND_QUERY, 0, 15, 1'b1, 0);
        add_row(KIND_TICK, 5, 10);
        add_row(KIND_QUERY, 10, 5, 1'b1, 1024);
        add_row(KIND_TICK, 10, 5);
        add_row(KIND_TICK, 10, 5);
        add_row(KIND_QUERY, 5, 10);
        add_row(KIND_QUERY, 10, 5);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].op, directed_rows[i].tick_region,
                      directed_rows[i].ask_region, directed_rows[i].typed,
                      directed_rows[i].typed_load, 1'b1);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            roll   = int'($urandom_range(99));
            tick_r = REGION_W'(($urandom_range(1) == 0) ? $urandom_range(3)
                                                         : $urandom_range(15));
            ask_r  = REGION_W'(($urandom_range(1) == 0) ? $urandom_range(3)
                                                         : $urandom_range(15));
            if (roll < 56)
                op = KIND_TICK;
            else if (roll < 93)
                op = KIND_QUERY;
            else if (roll < 96)
                op = KIND_CLEAR;
            else
                op = KIND_UNUSED;
            // no gaps in the middle stretch
            send_item(op, tick_r, ask_r, 1'b0, '0, (n < 150 || n >= 260));
        end
        start <= 1'b0;

        while (load_expected.size() != 0)
            @(posedge clk);
        drain = DRAIN_CYCLES;
        while (drain > 0)
        begin
            @(posedge clk);
            drain--;
        end

        $display("covered %0d ticks, %0d queries, %0d clears, %0d unused-kind commands",
                 n_ticks, n_queries, n_clears, n_ignored);
        $display("%0d load results checked, %0d mismatches", loads_checked, mismatches);
        if (mismatches == 0 && load_expected.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
